[rtl/core/assert_macros.svh]
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// implication, consequent checked on the clock edge after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/sas_pkg.sv]
package sas_pkg;

  localparam int unsigned NumSets        = 16;
  localparam int unsigned PatternsPerSet = 16;
  localparam int unsigned TimeBits       = 24;
  localparam int unsigned SetBits        = 4;
  localparam int unsigned PatBits        = 4;
  localparam int unsigned CntBits        = 5;
  localparam int unsigned TabDepth       = NumSets * PatternsPerSet;
  localparam int unsigned TabBits        = SetBits + PatBits;
  localparam int unsigned QueueDepth     = 2;

  typedef enum logic [3:0] {
    MODE_TICK      = 4'd0,
    MODE_START     = 4'd1,
    MODE_QUEUE     = 4'd2,
    MODE_CHG_SET   = 4'd3,
    MODE_CHG_LOOP  = 4'd4,
    MODE_PAUSE     = 4'd5,
    MODE_RESUME    = 4'd6,
    MODE_CLEAR     = 4'd7,
    MODE_WR_PAT    = 4'd8,
    MODE_WR_SET    = 4'd9,
    MODE_NOP_A     = 4'd10,
    MODE_NOP_B     = 4'd11,
    MODE_NOP_C     = 4'd12,
    MODE_NOP_D     = 4'd13,
    MODE_NOP_E     = 4'd14,
    MODE_NOP_F     = 4'd15
  } mode_e;

  typedef struct packed {
    logic [3:0]  mode;
    logic [3:0]  set_index;
    logic [3:0]  pattern_index;
    logic        loop_flag;
    logic        real_time_flag;
    logic [15:0] game_time_delta;
    logic [15:0] real_time_delta;
    logic [23:0] time_value;
    logic [4:0]  pattern_count;
  } cmd_t;

  typedef struct packed {
    logic        pattern_valid;
    logic [3:0]  pattern_index_res;
    logic [3:0]  current_set;
    logic [23:0] current_time;
    logic        running;
    logic        holding_end;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TOTAL,
    ST_MOD,
    ST_SEARCH_RD,
    ST_SEARCH,
    ST_HOLD_RD,
    ST_HOLD,
    ST_DONE
  } state_e;

endpackage

[rtl/core/sas_if.sv]
interface sas_cmd_if;
  sas_pkg::cmd_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sas_res_if;
  sas_pkg::res_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/sas_front.sv]
module sas_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  sas_cmd_if.sink             cmd_in,
  output sas_pkg::cmd_t       q_data_o,
  output logic                q_valid_o,
  input  logic                q_pop_i
);
  // small command queue between the accepting side and the executing side
  sas_pkg::cmd_t  mem_q [sas_pkg::QueueDepth];
  logic           wp_q, wp_d, rp_q, rp_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push;

  assign push          = cmd_in.valid && cmd_in.ready;
  assign cmd_in.ready  = (cnt_q != 2'(sas_pkg::QueueDepth));
  assign q_valid_o     = (cnt_q != 2'd0);
  assign q_data_o      = mem_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = q_pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= cmd_in.data;
    end
  end
endmodule

[rtl/core/sas_back.sv]
module sas_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [4:0]      set_count_i,
  input  sas_pkg::cmd_t   cmd_i,
  input  logic            cmd_valid_i,
  output logic            cmd_pop_o,
  sas_res_if.source       res_out
);
  localparam int unsigned TB = sas_pkg::TimeBits;

  // pattern end-time table, one read port
  logic [TB-1:0] pat_mem [sas_pkg::TabDepth];
  logic [TB-1:0] tot_mem [sas_pkg::NumSets];
  logic [4:0]    cnt_mem [sas_pkg::NumSets];

  sas_pkg::state_e state_q, state_d;

  logic [TB-1:0] tpos_q, tpos_d;
  logic [3:0]    aset_q, aset_d;
  logic          st_q, st_d, pa_q, pa_d, lp_q, lp_d, rt_q, rt_d;
  logic          qp_q, qp_d, ql_q, ql_d, qr_q, qr_d;
  logic [3:0]    qs_q, qs_d;
  logic          sv_q, sv_d;
  logic [3:0]    si_q, si_d;

  logic [TB:0]   dg_q, dg_d, dr_q, dr_d;
  logic          chained_q, chained_d;
  logic [TB:0]   t_q, t_d;        // grown time, shifted out msb first
  logic [TB-1:0] r_q, r_d;        // partial remainder
  logic [TB-1:0] tot_q, tot_d;
  logic [4:0]    cn_q, cn_d;
  logic [4:0]    i_q, i_d;
  logic [TB-1:0] rd_q;
  logic [TB-1:0] hold_tot_q, hold_tot_d;
  logic [4:0]    hold_cnt_q, hold_cnt_d;
  logic          res_v_q, res_v_d;
  sas_pkg::res_t res_q, res_d;

  logic          wr_pat, wr_set;
  logic [7:0]    rd_addr;
  logic          set_ok;
  logic [4:0]    pcnt;
  logic [TB:0]   tsum;
  logic [TB:0]   rem_sh;
  logic [TB-1:0] rem_nx;
  logic          hold;

  assign set_ok = ({1'b0, aset_q} < set_count_i);
  assign pcnt   = (cnt_mem[aset_q] > 5'(sas_pkg::PatternsPerSet)) ?
                  5'(sas_pkg::PatternsPerSet) : cnt_mem[aset_q];
  assign tsum   = {1'b0, tpos_q} + (pa_q ? '0 : (rt_q ? dr_q : dg_q));
  assign rd_addr = {aset_q, i_q[3:0]};
  assign rem_sh = {r_q, t_q[TB]};
  assign rem_nx = (rem_sh >= {1'b0, tot_q}) ? TB'(rem_sh - {1'b0, tot_q}) :
                  rem_sh[TB-1:0];

  assign wr_pat = (state_q == sas_pkg::ST_IDLE) && cmd_valid_i &&
                  (cmd_i.mode == sas_pkg::MODE_WR_PAT);
  assign wr_set = (state_q == sas_pkg::ST_IDLE) && cmd_valid_i &&
                  (cmd_i.mode == sas_pkg::MODE_WR_SET);

  always_ff @(posedge clk_i) begin
    if (wr_pat) pat_mem[{cmd_i.set_index, cmd_i.pattern_index}] <= cmd_i.time_value;
    if (wr_set) begin
      tot_mem[cmd_i.set_index] <= cmd_i.time_value;
      cnt_mem[cmd_i.set_index] <= cmd_i.pattern_count;
    end
    rd_q <= pat_mem[rd_addr];
  end

  assign res_out.valid = res_v_q;
  assign res_out.data  = res_q;

  always_comb begin
    state_d = state_q;
    tpos_d = tpos_q; aset_d = aset_q; st_d = st_q; pa_d = pa_q; lp_d = lp_q; rt_d = rt_q;
    qp_d = qp_q; ql_d = ql_q; qr_d = qr_q; qs_d = qs_q; sv_d = sv_q; si_d = si_q;
    dg_d = dg_q; dr_d = dr_q; chained_d = chained_q; t_d = t_q; r_d = r_q; tot_d = tot_q;
    cn_d = cn_q; i_d = i_q; hold_tot_d = hold_tot_q; hold_cnt_d = hold_cnt_q;
    res_v_d = res_v_q; res_d = res_q;
    cmd_pop_o = 1'b0;
    if (res_v_q && res_out.ready) res_v_d = 1'b0;
    unique case (state_q)
      sas_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          dg_d = {{(TB-15){1'b0}}, cmd_i.game_time_delta};
          dr_d = {{(TB-15){1'b0}}, cmd_i.real_time_delta};
          chained_d = 1'b0;
          state_d = sas_pkg::ST_HOLD_RD;
          case (cmd_i.mode)
            sas_pkg::MODE_TICK: state_d = sas_pkg::ST_CHECK;
            sas_pkg::MODE_START: begin
              tpos_d = '0; st_d = 1'b1; pa_d = 1'b0; aset_d = cmd_i.set_index;
              lp_d = cmd_i.loop_flag; rt_d = cmd_i.real_time_flag; qp_d = 1'b0;
            end
            sas_pkg::MODE_QUEUE: begin
              if (st_q) begin
                if (qp_q) begin
                  tpos_d = '0; pa_d = 1'b0; aset_d = qs_q; lp_d = 1'b0; rt_d = qr_q;
                end else begin
                  lp_d = 1'b0;
                end
                qp_d = 1'b1; qs_d = cmd_i.set_index;
                ql_d = cmd_i.loop_flag; qr_d = cmd_i.real_time_flag;
              end else begin
                tpos_d = '0; st_d = 1'b1; pa_d = 1'b0; aset_d = cmd_i.set_index;
                lp_d = cmd_i.loop_flag; rt_d = cmd_i.real_time_flag; qp_d = 1'b0;
              end
            end
            sas_pkg::MODE_CHG_SET: if (qp_q) qs_d = cmd_i.set_index; else aset_d = cmd_i.set_index;
            sas_pkg::MODE_CHG_LOOP: if (qp_q) ql_d = cmd_i.loop_flag; else lp_d = cmd_i.loop_flag;
            sas_pkg::MODE_PAUSE: pa_d = 1'b1;
            sas_pkg::MODE_RESUME: pa_d = 1'b0;
            sas_pkg::MODE_CLEAR: begin
              tpos_d = '0; aset_d = '0; st_d = 1'b0; pa_d = 1'b0; lp_d = 1'b0; rt_d = 1'b0;
              qp_d = 1'b0; ql_d = 1'b0; qr_d = 1'b0; qs_d = '0; sv_d = 1'b0; si_d = '0;
            end
            default: ;
          endcase
        end
      end
      sas_pkg::ST_CHECK: begin
        if (!set_ok || pcnt == 5'd0) begin
          sv_d = 1'b0; state_d = sas_pkg::ST_HOLD_RD;
        end else begin
          cn_d = pcnt; tot_d = tot_mem[aset_q];
          state_d = sas_pkg::ST_TOTAL;
        end
      end
      sas_pkg::ST_TOTAL: begin
        if (!st_q || tot_q == '0) begin
          sv_d = 1'b1; si_d = '0; state_d = sas_pkg::ST_HOLD_RD;
        end else if (!lp_q && tsum >= {1'b0, tot_q}) begin
          if (qp_q && !chained_q) begin
            // chain: overshoot becomes delta of queued animation
            dg_d = tsum - {1'b0, tot_q}; dr_d = dg_d;
            tpos_d = '0; st_d = 1'b1; pa_d = 1'b0; aset_d = qs_q;
            lp_d = ql_q; rt_d = qr_q; qp_d = 1'b0; chained_d = 1'b1;
            state_d = sas_pkg::ST_CHECK;
          end else begin
            tpos_d = tot_q; sv_d = 1'b1; si_d = 4'(cn_q - 5'd1);
            state_d = sas_pkg::ST_HOLD_RD;
          end
        end else if (tsum < {1'b0, tot_q}) begin
          tpos_d = tsum[TB-1:0]; i_d = '0; state_d = sas_pkg::ST_SEARCH_RD;
        end else begin
          t_d = tsum; r_d = '0; i_d = '0; state_d = sas_pkg::ST_MOD;
        end
      end
      sas_pkg::ST_MOD: begin
        // restoring remainder, one bit of the grown time per cycle
        r_d = rem_nx;
        t_d = {t_q[TB-1:0], 1'b0};
        if (i_q == 5'(TB)) begin
          tpos_d = rem_nx; i_d = '0; state_d = sas_pkg::ST_SEARCH_RD;
        end else begin
          i_d = i_q + 5'd1;
        end
      end
      sas_pkg::ST_SEARCH_RD: state_d = sas_pkg::ST_SEARCH;
      sas_pkg::ST_SEARCH: begin
        if (rd_q >= tpos_q) begin
          sv_d = 1'b1; si_d = i_q[3:0]; state_d = sas_pkg::ST_HOLD_RD;
        end else if (i_q + 5'd1 >= cn_q) begin
          state_d = sas_pkg::ST_HOLD_RD;
        end else begin
          i_d = i_q + 5'd1; state_d = sas_pkg::ST_SEARCH_RD;
        end
      end
      sas_pkg::ST_HOLD_RD: begin
        hold_tot_d = tot_mem[aset_q]; hold_cnt_d = pcnt;
        state_d = sas_pkg::ST_HOLD;
      end
      sas_pkg::ST_HOLD: state_d = sas_pkg::ST_DONE;
      sas_pkg::ST_DONE: begin
        // wait here while the previous beat still sits at the output
        if (!res_v_q || res_out.ready) begin
          res_v_d = 1'b1;
          res_d.pattern_valid = sv_q;
          res_d.pattern_index_res = sv_q ? si_q : 4'd0;
          res_d.current_set = aset_q;
          res_d.current_time = tpos_q;
          res_d.running = st_q;
          res_d.holding_end = hold;
          state_d = sas_pkg::ST_IDLE;
        end
      end
      default: state_d = sas_pkg::ST_IDLE;
    endcase
  end

  assign hold = st_q && !lp_q && set_ok && (hold_cnt_q != 5'd0) &&
                (hold_tot_q != '0) && (tpos_q >= hold_tot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sas_pkg::ST_IDLE;
      tpos_q <= '0; aset_q <= '0; st_q <= 1'b0; pa_q <= 1'b0; lp_q <= 1'b0; rt_q <= 1'b0;
      qp_q <= 1'b0; ql_q <= 1'b0; qr_q <= 1'b0; qs_q <= '0; sv_q <= 1'b0; si_q <= '0;
      res_v_q <= 1'b0; chained_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tpos_q <= tpos_d; aset_q <= aset_d; st_q <= st_d; pa_q <= pa_d; lp_q <= lp_d;
      rt_q <= rt_d; qp_q <= qp_d; ql_q <= ql_d; qr_q <= qr_d; qs_q <= qs_d;
      sv_q <= sv_d; si_q <= si_d; res_v_q <= res_v_d; chained_q <= chained_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dg_q <= dg_d; dr_q <= dr_d; t_q <= t_d; r_q <= r_d; tot_q <= tot_d; cn_q <= cn_d;
    i_q <= i_d; hold_tot_q <= hold_tot_d; hold_cnt_q <= hold_cnt_d; res_q <= res_d;
  end
endmodule

[rtl/core/sprite_animation_sequencer_core.sv]
// channel  dir  payload
// cmd_in   in   cmd_t: mode, set/pattern index, flags, deltas, time, count
// res_out  out  res_t: selection, set, time, running, holding_end
// a command passes the back part's hold-read, hold and done states; a tick first adds set
// checks, a 25-step remainder when a looping time passes the total, a table read and a
// compare per pattern searched, and a second check when a one-shot chains into the queued one
// a beat becomes visible to the back part in the cycle after it enters the queue
// reset clears play state and the queue; tables are undefined until written
// the queue lets two commands wait while a result stalls at the output
module sprite_animation_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  sas_cmd_if.sink     cmd_in,
  sas_res_if.source   res_out
);
  logic [4:0]         set_count_q;
  sas_pkg::cmd_t      qd;
  logic               qv, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) set_count_q <= '0;
    else if (cfg_we_i) set_count_q <= cfg_wdata_i;
  end

  sas_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_in(cmd_in),
    .q_data_o(qd), .q_valid_o(qv), .q_pop_i(pop)
  );

  sas_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .set_count_i(set_count_q),
    .cmd_i(qd), .cmd_valid_i(qv), .cmd_pop_o(pop), .res_out(res_out)
  );
endmodule

[rtl/core/sas_checker.sv]
`include "assert_macros.svh"
module sas_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic res_valid,
  input logic res_ready,
  input sas_pkg::res_t res_data
);
  logic idx_ok, hold_ok;

  assign idx_ok  = res_data.pattern_valid || (res_data.pattern_index_res == 4'd0);
  assign hold_ok = !res_data.holding_end || res_data.running;

  `ASSERT_ALWAYS(a_idx_zero, clk_i, rst_ni, !res_valid || idx_ok)
  `ASSERT_ALWAYS(a_hold_run, clk_i, rst_ni, !res_valid || hold_ok)
  `ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid && !res_ready, res_valid && $stable(res_data))
endmodule

bind sprite_animation_sequencer_core sas_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .res_valid(res_out.valid), .res_ready(res_out.ready), .res_data(res_out.data)
);

[tb/sv/tb_top.sv]
module tb_top;
  import sas_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 80;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [4:0] cfg_wdata_i;

  sas_cmd_if cmd_bus ();
  sas_res_if res_bus ();

  sprite_animation_sequencer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_in      (cmd_bus.sink),
    .res_out     (res_bus.source)
  );

  // shadow copy of the sequencer
  logic [23:0] pat_end_tab [TabDepth];
  logic [23:0] set_total_tab [NumSets];
  logic [4:0]  set_cnt_tab [NumSets];
  logic [4:0]  loaded_sets;
  longint unsigned anim_pos;
  logic [3:0] anim_set;
  logic anim_started, anim_paused, anim_loop, anim_rt;
  logic que_pending, que_loop, que_rt;
  logic [3:0] que_set;
  logic pick_valid;
  logic [3:0] pick_idx;

  res_t frame_q [$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_cnt;
  bit failed;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void play_start(logic [3:0] s, logic l, logic r);
    anim_pos = 0;
    anim_started = 1'b1;
    anim_paused = 1'b0;
    anim_set = s;
    anim_loop = l;
    anim_rt = r;
    que_pending = 1'b0;
  endfunction

  function automatic void play_clear();
    anim_pos = 0;
    anim_set = '0;
    {anim_started, anim_paused, anim_loop, anim_rt} = '0;
    {que_pending, que_loop, que_rt} = '0;
    que_set = '0;
    pick_valid = 1'b0;
    pick_idx = '0;
  endfunction

  function automatic bit set_usable(logic [3:0] s);
    return ({1'b0, s} < loaded_sets);
  endfunction

  function automatic int unsigned set_pats(logic [3:0] s);
    return (set_cnt_tab[s] > PatternsPerSet) ? PatternsPerSet : set_cnt_tab[s];
  endfunction

  function automatic void advance_time(longint unsigned dg, longint unsigned dr);
    int unsigned cnt;
    longint unsigned tot;
    longint unsigned t;
    while (1) begin
      if (!set_usable(anim_set)) begin
        pick_valid = 1'b0;
        return;
      end
      cnt = set_pats(anim_set);
      if (cnt == 0) begin
        pick_valid = 1'b0;
        return;
      end
      tot = set_total_tab[anim_set];
      if (!anim_started || tot == 0) begin
        pick_valid = 1'b1;
        pick_idx = '0;
        return;
      end
      t = anim_pos;
      if (!anim_paused) t += anim_rt ? dr : dg;
      if (!anim_loop && t >= tot) begin
        if (que_pending) begin
          // chain into the queued animation, carrying the overshoot
          dg = t - tot;
          dr = t - tot;
          play_start(que_set, que_loop, que_rt);
          continue;
        end
        anim_pos = tot;
        pick_valid = 1'b1;
        pick_idx = 4'(cnt - 1);
        return;
      end
      t = t % tot;
      anim_pos = t;
      for (int i = 0; i < cnt; i++) begin
        if (pat_end_tab[{anim_set, 4'(i)}] >= t) begin
          pick_valid = 1'b1;
          pick_idx = 4'(i);
          return;
        end
      end
      return;
    end
  endfunction

  function automatic res_t predict_frame(cmd_t c);
    res_t r;
    case (mode_e'(c.mode))
      MODE_TICK: advance_time(c.game_time_delta, c.real_time_delta);
      MODE_START: play_start(c.set_index, c.loop_flag, c.real_time_flag);
      MODE_QUEUE: begin
        if (anim_started) begin
          if (que_pending) play_start(que_set, 1'b0, que_rt);
          else anim_loop = 1'b0;
          que_pending = 1'b1;
          que_set = c.set_index;
          que_loop = c.loop_flag;
          que_rt = c.real_time_flag;
        end else begin
          play_start(c.set_index, c.loop_flag, c.real_time_flag);
        end
      end
      MODE_CHG_SET: if (que_pending) que_set = c.set_index; else anim_set = c.set_index;
      MODE_CHG_LOOP: if (que_pending) que_loop = c.loop_flag; else anim_loop = c.loop_flag;
      MODE_PAUSE: anim_paused = 1'b1;
      MODE_RESUME: anim_paused = 1'b0;
      MODE_CLEAR: play_clear();
      MODE_WR_PAT: pat_end_tab[{c.set_index, c.pattern_index}] = c.time_value;
      MODE_WR_SET: begin
        set_total_tab[c.set_index] = c.time_value;
        set_cnt_tab[c.set_index] = c.pattern_count;
      end
      default: ;
    endcase
    r.pattern_valid = pick_valid;
    r.pattern_index_res = pick_valid ? pick_idx : '0;
    r.current_set = anim_set;
    r.current_time = anim_pos[23:0];
    r.running = anim_started;
    r.holding_end = anim_started && !anim_loop && set_usable(anim_set) &&
                    set_pats(anim_set) != 0 && set_total_tab[anim_set] != 0 &&
                    anim_pos >= set_total_tab[anim_set];
    return r;
  endfunction

  task automatic send_cmd(cmd_t c);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    cmd_bus.valid = 1'b1;
    cmd_bus.data = c;
    do @(posedge clk_i); while (!cmd_bus.ready);
    frame_q.push_back(predict_frame(c));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    cmd_bus.valid = 1'b0;
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_set_count(logic [4:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    loaded_sets = v;
  endtask

  function automatic cmd_t mk_cmd(mode_e m, logic [3:0] s);
    cmd_t c;
    c = '0;
    c.mode = m;
    c.set_index = s;
    return c;
  endfunction

  // receiver side: random backpressure and in-order comparison
  always begin
    @(negedge clk_i);
    res_bus.ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (frame_q.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, res_bus.data);
        failed = 1'b1;
      end else begin
        exp_r = frame_q.pop_front();
        if (exp_r !== res_bus.data) begin
          $display("%0t: mismatch expected valid=%0d idx=%0d set=%0d time=%0d run=%0d hold=%0d",
                   $time, exp_r.pattern_valid, exp_r.pattern_index_res, exp_r.current_set,
                   exp_r.current_time, exp_r.running, exp_r.holding_end);
          $display("%0t: mismatch actual   valid=%0d idx=%0d set=%0d time=%0d run=%0d hold=%0d",
                   $time, res_bus.data.pattern_valid, res_bus.data.pattern_index_res,
                   res_bus.data.current_set, res_bus.data.current_time,
                   res_bus.data.running, res_bus.data.holding_end);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // fill every table entry before any set becomes visible
  task automatic test_table_load();
    cmd_t c;
    logic [23:0] acc;
    for (int s = 0; s < NumSets; s++) begin
      c = mk_cmd(MODE_WR_SET, 4'(s));
      c.time_value = (s == 15) ? 24'hFFFFFF : 24'($urandom_range(50, 600));
      c.pattern_count = (s == 3) ? 5'd0 : (s == 4) ? 5'd31 : 5'($urandom_range(1, 16));
      send_cmd(c);
      acc = '0;
      for (int p = 0; p < PatternsPerSet; p++) begin
        acc = acc + 24'($urandom_range(5, 60));
        c = mk_cmd(MODE_WR_PAT, 4'(s));
        c.pattern_index = 4'(p);
        c.time_value = (s == 15 && p == 15) ? 24'hFFFFFF : acc;
        send_cmd(c);
      end
    end
  endtask

  task automatic tick(logic [15:0] g, logic [15:0] r);
    cmd_t c;
    c = mk_cmd(MODE_TICK, 4'($urandom));
    c.game_time_delta = g;
    c.real_time_delta = r;
    send_cmd(c);
  endtask

  task automatic test_directed();
    cmd_t c;
    tick(16'hFFFF, 16'hFFFF);              // tables loaded, no set visible yet
    write_set_count(5'd16);
    c = mk_cmd(MODE_START, 4'd0); c.loop_flag = 1'b1; send_cmd(c);
    tick(16'd100, 16'd0);
    tick(16'hFFFF, 16'd0);                 // wrap on looping set
    c = mk_cmd(MODE_QUEUE, 4'd1); c.real_time_flag = 1'b1; send_cmd(c);
    c = mk_cmd(MODE_QUEUE, 4'd2); c.loop_flag = 1'b1; send_cmd(c);   // queue while queued
    tick(16'hFFFF, 16'd40);                // real-time step stays short of the total
    c = mk_cmd(MODE_CHG_SET, 4'd5); send_cmd(c);
    c = mk_cmd(MODE_CHG_LOOP, 4'd0); send_cmd(c);
    c = mk_cmd(MODE_PAUSE, 4'd0); send_cmd(c);
    tick(16'd500, 16'd500);
    c = mk_cmd(MODE_RESUME, 4'd0); send_cmd(c);
    tick(16'hFFFF, 16'hFFFF);              // one-shot holds
    c = mk_cmd(MODE_START, 4'd3); send_cmd(c);
    tick(16'd10, 16'd10);                  // empty set
    c = mk_cmd(MODE_START, 4'd4); send_cmd(c);
    tick(16'd7, 16'd7);                    // oversize pattern count
    c = mk_cmd(MODE_START, 4'd15); send_cmd(c);
    tick(16'hFFFF, 16'hFFFF);
    c = mk_cmd(MODE_CLEAR, 4'd0); send_cmd(c);
    tick(16'd1, 16'd1);                    // not started
    for (int m = 0; m < 6; m++) send_cmd(mk_cmd(mode_e'(MODE_NOP_A + m), 4'($urandom)));
  endtask

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int unsigned w;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    c = raw[$bits(cmd_t)-1:0];
    w = $urandom_range(0, 99);
    if (w < 48) c.mode = MODE_TICK;
    else if (w < 58) c.mode = MODE_START;
    else if (w < 66) c.mode = MODE_QUEUE;
    else if (w < 70) c.mode = MODE_CHG_SET;
    else if (w < 74) c.mode = MODE_CHG_LOOP;
    else if (w < 77) c.mode = MODE_PAUSE;
    else if (w < 80) c.mode = MODE_RESUME;
    else if (w < 82) c.mode = MODE_CLEAR;
    else if (w < 89) c.mode = MODE_WR_PAT;
    else if (w < 95) c.mode = MODE_WR_SET;
    else c.mode = mode_e'(MODE_NOP_A + $urandom_range(0, 5));
    // mostly short steps so animations play through their patterns
    if ($urandom_range(0, 9) < 8) begin
      c.game_time_delta = 16'($urandom_range(0, 300));
      c.real_time_delta = 16'($urandom_range(0, 300));
    end
    if (c.mode == MODE_WR_SET || c.mode == MODE_WR_PAT) begin
      if ($urandom_range(0, 9) < 8) c.time_value = 24'($urandom_range(0, 1200));
      if ($urandom_range(0, 19) == 0) c.time_value = '0;
      if ($urandom_range(0, 9) < 7) c.pattern_count = 5'($urandom_range(1, 16));
    end
    return c;
  endfunction

  task automatic test_random(int unsigned n);
    repeat (n) send_cmd(rand_cmd());
  endtask

  initial begin
    failed = 1'b0;
    cycle_cnt = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.data = '0;
    res_bus.ready = 1'b0;
    loaded_sets = '0;
    play_clear();
    send_idle_pct = 28;
    recv_idle_pct = 74;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_table_load();
    test_directed();
    test_random(120);
    write_set_count(5'd5);
    send_idle_pct = 74;
    recv_idle_pct = 28;
    test_random(80);
    write_set_count(5'd31);
    test_random(60);
    write_set_count(5'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(40);
    write_set_count(5'd1);
    test_random(40);
    write_set_count(5'd16);
    test_random(100);
    wait_idle();

    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/sas_pkg.sv
rtl/core/sas_if.sv
rtl/core/sas_front.sv
rtl/core/sas_back.sv
rtl/core/sprite_animation_sequencer_core.sv
rtl/core/sas_checker.sv
tb/sv/tb_top.sv
